/* rtl/core/binary_to_decimal_ascii_core_defines.svh */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core_defines
// assertion macros shared by the decimal ascii core
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define B2DA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("b2da assertion failed");

// antecedent at one edge implies consequent at the next edge
`define B2DA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b2da assertion failed");

`else

`define B2DA_ASSERT_ALWAYS(lbl, expr)
`define B2DA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// types, constants and the shift-add-3 step of the decimal ascii core
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int BIN_W        = 32;
    localparam int NUM_DIGITS   = 10;
    localparam int DD_STAGES    = 8;
    localparam int DD_PER_STAGE = BIN_W / DD_STAGES;
    localparam int CHAR_W       = 6;
    localparam int POS_W        = 4;
    localparam int OUT_DATA_W   = 16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        t_bcd             bcd;
        logic [BIN_W-1:0] bin;
    } t_dd;

    // one double dabble iteration: adjust digits, then shift in one bit
    function automatic t_dd dd_step(input t_dd x);
        t_dd y;
        y = x;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (y.bcd[d] >= 4'd5) begin
                y.bcd[d] = y.bcd[d] + 4'd3;
            end
        end
        {y.bcd, y.bin} = {y.bcd, y.bin} << 1;
        return y;
    endfunction

endpackage

/* rtl/core/binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// unsigned 32-bit value to decimal ascii digits, most significant first,
// leading zeros suppressed
//
// channel   dir   tdata                               tlast
// s         in    [31:0] value                        -
// m         out   [5:0] ascii_char, [9:6] char_pos    last_char
//
// eight double dabble stages of four steps, one digit count stage, then
// a character register that sends one digit per cycle while the receiver is ready
// an item may enter every cycle unless the pipeline holds; a number of n digits
// (1 to 10) occupies the character register until all its characters are sent,
// which sets the sustained rate; the whole pipeline holds while its last stage
// waits on the character register; synchronous active-low reset clears all
// valid bits
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_defines.svh"

module binary_to_decimal_ascii_core
    import b2da_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BIN_W-1:0]      i_s_tdata,   // [31:0] value
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [5:0] ascii_char, [9:6] char_position
    output logic                  o_m_tlast    // last_char
);

    t_dd                  r_dd [DD_STAGES];
    t_dd                  n_dd [DD_STAGES];
    logic [DD_STAGES-1:0] r_dd_v;

    logic                 r_c_v;
    t_bcd                 r_c_bcd;
    logic [POS_W-1:0]     r_c_n;
    logic [POS_W-1:0]     n_c_n;

    logic                 r_sv;
    t_bcd                 r_bcd;
    logic [POS_W-1:0]     r_idx;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     r_n;

    logic                 en;
    logic                 load_ser;
    logic                 emit;
    logic [3:0]           cur_digit;

    assign emit      = r_sv && i_m_tready;
    assign load_ser  = !r_sv || (i_m_tready && (r_idx == '0));
    assign en        = !r_c_v || load_ser;
    assign o_s_tready = en;

    // double dabble stages
    for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
        t_dd x_in;
        if (s == 0) begin : g_first
            assign x_in.bcd = '0;
            assign x_in.bin = i_s_tdata;
        end else begin : g_rest
            assign x_in = r_dd[s-1];
        end
        always_comb begin
            t_dd x;
            x = x_in;
            for (int k = 0; k < DD_PER_STAGE; k++) begin
                x = dd_step(x);
            end
            n_dd[s] = x;
        end
    end

    // number of significant digits
    always_comb begin
        n_c_n = POS_W'(1);
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (r_dd[DD_STAGES-1].bcd[d] != 4'd0) begin
                n_c_n = POS_W'(d + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dd_v <= '0;
            r_c_v  <= 1'b0;
        end else if (en) begin
            r_dd_v <= {r_dd_v[DD_STAGES-2:0], i_s_tvalid};
            r_c_v  <= r_dd_v[DD_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < DD_STAGES; s++) begin
                r_dd[s] <= n_dd[s];
            end
            r_c_bcd <= r_dd[DD_STAGES-1].bcd;
            r_c_n   <= n_c_n;
        end
    end

    // character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (load_ser) begin
            r_sv <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ser) begin
            r_bcd <= r_c_bcd;
            r_n   <= r_c_n;
            r_idx <= r_c_n - POS_W'(1);
            r_pos <= '0;
        end else if (emit) begin
            r_idx <= r_idx - POS_W'(1);
            r_pos <= r_pos + POS_W'(1);
        end
    end

    assign cur_digit  = r_bcd[r_idx];
    assign o_m_tvalid = r_sv;
    assign o_m_tlast  = (r_idx == '0);
    assign o_m_tdata  = {(OUT_DATA_W - CHAR_W - POS_W)'(0), r_pos,
                         ASCII_ZERO + {2'b00, cur_digit}};

    `B2DA_ASSERT_ALWAYS(a_pos_idx_sum, !r_sv || ((r_pos + r_idx) == (r_n - POS_W'(1))))
    `B2DA_ASSERT_ALWAYS(a_lead_nonzero, !r_sv || (r_n == POS_W'(1)) || (r_bcd[r_n - POS_W'(1)] != 4'd0))
    `B2DA_ASSERT_NEXT(a_drain, r_sv && i_m_tready && o_m_tlast && !r_c_v, !r_sv)
    `B2DA_ASSERT_NEXT(a_hold_when_busy, r_sv && !o_m_tlast, !o_s_tready || !r_c_v || r_sv)

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the decimal ascii core against an in-bench digit predictor: every
// accepted number is expanded into its expected characters, and each output
// item is compared with the oldest pending character; directed edge values,
// digit-count-weighted random values, full-rate streaming, a long output
// hold that backs the pipeline up, and a pause that lets it drain
// ----------------------------------------------------------------------------
module tb
    import b2da_pkg::*;
();

    localparam int          DEC_BASE     = 10;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned MAX_VALUE    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_digit_char;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [BIN_W-1:0]      i_s_tdata  = '0;   // [31:0] value
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // [5:0] ascii_char, [9:6] char_position
    logic                  o_m_tlast;         // last_char

    t_digit_char pending_chars[$];
    int          err_count   = 0;
    int          burst_left  = 0;
    int          gap_max     = 4;
    int          burst_max   = 8;
    logic [15:0] ready_pat   = 16'hFFFF;
    logic [3:0]  ready_idx   = '0;
    int          hold_asked  = 0;
    int          hold_served = 0;
    int          hold_left   = 0;

    binary_to_decimal_ascii_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // expected characters of one number, most significant first
    function automatic void queue_decimal_chars(input logic [BIN_W-1:0] value);
        logic [3:0]       rev [NUM_DIGITS];
        logic [BIN_W-1:0] rest;
        int               n;
        t_digit_char      c;
        rest = value;
        n    = 0;
        do begin
            rev[n] = 4'(rest % DEC_BASE);
            rest   = rest / DEC_BASE;
            n++;
        end while (rest != 0 && n < NUM_DIGITS);
        for (int k = 0; k < n; k++) begin
            c.ascii = ASCII_ZERO + CHAR_W'(rev[n-1-k]);
            c.pos   = POS_W'(k);
            c.last  = (k == n - 1);
            pending_chars.push_back(c);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    // receiver: rotating stall pattern, overridden by a long hold on request
    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ready_pat[ready_idx];
        end
        ready_idx <= ready_idx + 4'd1;
    end

    always @(posedge i_clk) begin
        t_digit_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("item with none pending", 0, o_m_tdata);
            end else begin
                want = pending_chars.pop_front();
                if (o_m_tdata[CHAR_W-1:0] !== want.ascii)
                    report_mismatch("ascii_char", want.ascii, o_m_tdata[CHAR_W-1:0]);
                if (o_m_tdata[CHAR_W+POS_W-1:CHAR_W] !== want.pos)
                    report_mismatch("char_position", want.pos,
                                    o_m_tdata[CHAR_W+POS_W-1:CHAR_W]);
                if (o_m_tlast !== want.last)
                    report_mismatch("last_char", want.last, o_m_tlast);
            end
        end
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, burst_max);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_value(input logic [BIN_W-1:0] value);
        pace();
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        queue_decimal_chars(value);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // value with a random digit count (or, three times in ten, any 32-bit value), so short strings are common too
    function automatic logic [BIN_W-1:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        int              digits;
        if ($urandom_range(0, 9) < 3) return $urandom;
        digits = $urandom_range(1, NUM_DIGITS);
        lo     = 1;
        for (int k = 1; k < digits; k++) lo = lo * DEC_BASE;
        hi = lo * DEC_BASE - 1;
        if (hi > MAX_VALUE) hi = MAX_VALUE;
        if (digits == 1) lo = 0;
        return $urandom_range(int'(hi), int'(lo));
    endfunction

    task automatic test_directed();
        logic [BIN_W-1:0] vals[$];
        vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
                 32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
                 32'd2147483648, 32'd3999999999, 32'd4000000000, 32'd4294967294,
                 MAX_VALUE, 32'hAAAA_AAAA, 32'h5555_5555, 32'd90807060, 32'd0,
                 MAX_VALUE};
        gap_max   = 3;
        burst_max = 4;
        ready_pat = 16'hEF7B;
        foreach (vals[i]) send_value(vals[i]);
    endtask

    task automatic test_random_values();
        for (int i = 0; i < 150; i++) begin
            if (i % 45 == 0) begin
                gap_max   = $urandom_range(0, 20);
                burst_max = $urandom_range(1, 12);
                ready_pat = 16'($urandom | $urandom) | 16'h0001;
            end
            send_value(random_value());
        end
    endtask

    task automatic test_full_rate();
        gap_max   = 0;
        burst_max = 1;
        ready_pat = 16'hFFFF;
        for (int i = 0; i < 50; i++) send_value(random_value());
    endtask

    task automatic test_output_hold();
        gap_max   = 0;
        burst_max = 1;
        ready_pat = 16'hFFFF;
        hold_asked++;
        for (int i = 0; i < 40; i++) send_value($urandom);
    endtask

    task automatic test_drain_pause();
        gap_max   = 2;
        burst_max = 6;
        ready_pat = 16'hB6DB;
        for (int i = 0; i < 10; i++) send_value(random_value());
        wait_drained();
        for (int i = 0; i < 10; i++) send_value(random_value());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_values();
        test_full_rate();
        test_output_hold();
        test_drain_pause();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* binary_to_decimal_ascii_core.f */
+incdir+rtl/core
rtl/core/b2da_pkg.sv
rtl/core/binary_to_decimal_ascii_core.sv
bench/tb.sv
